// File: rtl/cmap_li_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the colour gradient pipeline.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package cmap_li_pkg;

   localparam int CHAN_W      = 8;
   localparam int N_CHAN      = 3;
   localparam int RGB_W       = N_CHAN * CHAN_W;
   localparam int POS_SHIFT   = 24;
   localparam int CSR_IDX_W   = 4;
   // quotient bits: eight result bits plus one saturation bit
   localparam int Q_W         = 9;
   localparam int DIV_STAGES  = 3;
   localparam int DIV_STEPS   = 3;
   // seg, three arithmetic, three divider, output
   localparam int N_STAGES    = 8;
   localparam int ST_SEG      = 0;
   localparam int ST_ARITH    = 1;
   localparam int ST_DIV      = 4;
   localparam int ST_OUT      = 7;

   localparam logic [RGB_W-1:0] WHITE_RGB = '1;

   // element 0 is red, 1 green, 2 blue
   typedef logic [N_CHAN-1:0][CHAN_W-1:0] rgb_type;

   typedef logic [N_STAGES-1:0] stage_en_type;

   typedef struct packed {
      logic              err;
      logic              zero;
      logic              use_cb;
      logic [CHAN_W-1:0] cb;
   } chan_tag_type;

   // width of the signed blend numerator for a given fraction width
   function automatic int num_w(input int frac_bits);
      return frac_bits + 12;
   endfunction

   // register colour field is red 23..16, green 15..8, blue 7..0
   function automatic rgb_type reg_colour(input logic [RGB_W-1:0] f);
      rgb_type c;
      c[0] = f[23:16];
      c[1] = f[15:8];
      c[2] = f[7:0];
      return c;
   endfunction

endpackage

// File: rtl/cmap_li_seg.sv
`timescale 1ns / 1ps
// Segment search stage: picks the bracketing control points for a position.
// Depends on cmap_li_pkg.
module cmap_li_seg #(
   parameter int NUM_POINTS = 8,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [FRAC_BITS:0]           x_i,
   input  logic [NUM_POINTS-1:0][cmap_li_pkg::POS_SHIFT+FRAC_BITS:0] points,
   output logic [FRAC_BITS:0]           x_ff,
   output logic [FRAC_BITS:0]           pa_ff,
   output logic [FRAC_BITS:0]           pb_ff,
   output cmap_li_pkg::rgb_type         ca_ff,
   output cmap_li_pkg::rgb_type         cb_ff,
   output logic                         err_ff
);

   localparam int PS = cmap_li_pkg::POS_SHIFT;
   localparam logic [FRAC_BITS:0] ONE_POS = {1'b1, {FRAC_BITS{1'b0}}};

   logic [FRAC_BITS:0]   pa_in;
   logic [FRAC_BITS:0]   pb_in;
   cmap_li_pkg::rgb_type ca_in;
   cmap_li_pkg::rgb_type cb_in;
   logic                 err_in;

   // first segment whose upper point is not below x, else the last one
   always_comb begin
      logic found;
      logic hit;
      pa_in = '0;
      pb_in = '0;
      ca_in = '0;
      cb_in = '0;
      found = 1'b0;
      for (int i = 0; i < NUM_POINTS - 1; i++) begin
         hit = (i == NUM_POINTS - 2) || (points[i+1][PS+FRAC_BITS:PS] >= x_i);
         if (hit && !found) begin
            pa_in = points[i][PS+FRAC_BITS:PS];
            pb_in = points[i+1][PS+FRAC_BITS:PS];
            ca_in = cmap_li_pkg::reg_colour(points[i][cmap_li_pkg::RGB_W-1:0]);
            cb_in = cmap_li_pkg::reg_colour(points[i+1][cmap_li_pkg::RGB_W-1:0]);
         end
         found = found | hit;
      end
      err_in = x_i > ONE_POS;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_i;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         ca_ff  <= ca_in;
         cb_ff  <= cb_in;
         err_ff <= err_in;
      end
   end

endmodule

// File: rtl/cmap_li_arith.sv
`timescale 1ns / 1ps
// Blend arithmetic: differences, weighted sums and magnitudes, three stages.
// Depends on cmap_li_pkg.
module cmap_li_arith #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic [2:0]                   en,
   input  logic [FRAC_BITS:0]           x_i,
   input  logic [FRAC_BITS:0]           pa_i,
   input  logic [FRAC_BITS:0]           pb_i,
   input  cmap_li_pkg::rgb_type         ca_i,
   input  cmap_li_pkg::rgb_type         cb_i,
   input  logic                         err_i,
   output logic [cmap_li_pkg::N_CHAN-1:0][cmap_li_pkg::num_w(FRAC_BITS)-1:0] mag_n_ff,
   output logic [FRAC_BITS:0]           mag_d_ff,
   output cmap_li_pkg::chan_tag_type [cmap_li_pkg::N_CHAN-1:0] tag_ff
);

   localparam int PW  = FRAC_BITS + 1;
   localparam int DW  = PW + 1;
   localparam int PRW = DW + 9;
   localparam int NW  = cmap_li_pkg::num_w(FRAC_BITS);
   localparam int NC  = cmap_li_pkg::N_CHAN;

   // stage A: position differences
   logic signed [DW-1:0] dxa_in, dxb_in, den_a_in;
   logic signed [DW-1:0] dxa_ff, dxb_ff, den_a_ff;
   cmap_li_pkg::rgb_type ca_a_ff, cb_a_ff;
   logic                 err_a_ff;

   // stage B: weighted numerators
   logic signed [NW-1:0] num_in [NC];
   logic signed [NW-1:0] num_ff [NC];
   logic signed [DW-1:0] den_b_ff;
   cmap_li_pkg::rgb_type cb_b_ff;
   logic                 err_b_ff;

   // stage C: magnitudes and flags
   logic [NC-1:0][NW-1:0]                        mag_n_in;
   logic [PW-1:0]                                mag_d_in;
   cmap_li_pkg::chan_tag_type [NC-1:0]           tag_in;

   assign dxa_in   = $signed({1'b0, x_i})  - $signed({1'b0, pa_i});
   assign dxb_in   = $signed({1'b0, pb_i}) - $signed({1'b0, x_i});
   assign den_a_in = $signed({1'b0, pb_i}) - $signed({1'b0, pa_i});

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dxa_ff   <= dxa_in;
         dxb_ff   <= dxb_in;
         den_a_ff <= den_a_in;
         ca_a_ff  <= ca_i;
         cb_a_ff  <= cb_i;
         err_a_ff <= err_i;
      end
   end

   always_comb begin
      logic signed [PRW-1:0] prod_a;
      logic signed [PRW-1:0] prod_b;
      for (int c = 0; c < NC; c++) begin
         prod_a    = $signed({1'b0, cb_a_ff[c]}) * dxa_ff;
         prod_b    = $signed({1'b0, ca_a_ff[c]}) * dxb_ff;
         num_in[c] = NW'(prod_a) + NW'(prod_b);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int c = 0; c < NC; c++) begin
            num_ff[c] <= num_in[c];
         end
         den_b_ff <= den_a_ff;
         cb_b_ff  <= cb_a_ff;
         err_b_ff <= err_a_ff;
      end
   end

   // quotient sign from operand signs; a zero width hands over point b
   always_comb begin
      logic [NW-1:0] nb;
      logic [DW-1:0] db;
      logic [DW-1:0] dm;
      logic          dz;
      db       = den_b_ff;
      dm       = db[DW-1] ? (~db + DW'(1)) : db;
      mag_d_in = dm[PW-1:0];
      dz       = (db == '0);
      for (int c = 0; c < NC; c++) begin
         nb                 = num_ff[c];
         mag_n_in[c]        = nb[NW-1] ? (~nb + NW'(1)) : nb;
         tag_in[c].err      = err_b_ff;
         tag_in[c].zero     = err_b_ff | (!dz & (nb[NW-1] ^ db[DW-1]));
         tag_in[c].use_cb   = dz;
         tag_in[c].cb       = cb_b_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         mag_n_ff <= mag_n_in;
         mag_d_ff <= mag_d_in;
         tag_ff   <= tag_in;
      end
   end

endmodule

// File: rtl/cmap_li_div.sv
`timescale 1ns / 1ps
// Saturating restoring divider for one channel, three quotient bits a stage.
// Depends on cmap_li_pkg.
module cmap_li_div #(
   parameter int NW = 28,
   parameter int DW = 17
) (
   input  logic                      clock,
   input  logic [2:0]                en,
   input  logic [NW-1:0]             rem_i,
   input  logic [DW-1:0]             d_i,
   input  cmap_li_pkg::chan_tag_type tag_i,
   output logic [cmap_li_pkg::CHAN_W-1:0] val_o,
   output logic                      err_o
);

   localparam int NS = cmap_li_pkg::DIV_STAGES;
   localparam int QW = cmap_li_pkg::Q_W;

   logic [NW-1:0]             rem_ff [NS];
   logic [QW-1:0]             q_ff   [NS];
   logic [DW-1:0]             d_ff   [NS];
   cmap_li_pkg::chan_tag_type tag_ff [NS];

   logic [NW-1:0]             rem_src [NS];
   logic [QW-1:0]             q_src   [NS];
   logic [DW-1:0]             d_src   [NS];
   cmap_li_pkg::chan_tag_type tag_src [NS];

   logic [NW-1:0]             rem_in  [NS];
   logic [QW-1:0]             q_in    [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign rem_src[s] = rem_i;
         assign q_src[s]   = '0;
         assign d_src[s]   = d_i;
         assign tag_src[s] = tag_i;
      end else begin : g_next
         assign rem_src[s] = rem_ff[s-1];
         assign q_src[s]   = q_ff[s-1];
         assign d_src[s]   = d_ff[s-1];
         assign tag_src[s] = tag_ff[s-1];
      end

      always_comb begin
         logic [NW-1:0] r;
         logic [QW-1:0] q;
         logic [NW-1:0] dsh;
         int            k;
         r = rem_src[s];
         q = q_src[s];
         for (int j = 0; j < cmap_li_pkg::DIV_STEPS; j++) begin
            k   = QW - 1 - s * cmap_li_pkg::DIV_STEPS - j;
            dsh = NW'(d_src[s]) << k;
            if (r >= dsh) begin
               r    = r - dsh;
               q[k] = 1'b1;
            end
         end
         rem_in[s] = r;
         q_in[s]   = q;
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in[s];
            q_ff[s]   <= q_in[s];
            d_ff[s]   <= d_src[s];
            tag_ff[s] <= tag_src[s];
         end
      end
   end

   // top quotient bit set means the quotient reached 256: clamp to full scale
   always_comb begin
      if (tag_ff[NS-1].zero) begin
         val_o = '0;
      end else if (tag_ff[NS-1].use_cb) begin
         val_o = tag_ff[NS-1].cb;
      end else if (q_ff[NS-1][QW-1]) begin
         val_o = '1;
      end else begin
         val_o = q_ff[NS-1][cmap_li_pkg::CHAN_W-1:0];
      end
   end

   assign err_o = tag_ff[NS-1].err;

endmodule

// File: rtl/colormap_linear_interp_top.sv
`timescale 1ns / 1ps
// Eight register stages: segment search, arithmetic, divider and output.
// Throughput: one item per clock unless rsp_tready stalls; the longest stages are the
//   two 8 x 18 products per channel and the three-bit steps of the divider.
// Reset (synchronous, active high): clears every stage valid bit and loads
//   point0 with black at 0.0 and the other points with white at 1.0.
// Depends on cmap_li_pkg, cmap_li_seg, cmap_li_arith and cmap_li_div.
module colormap_linear_interp_top #(
   parameter int NUM_POINTS = 8,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // item in
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [FRAC_BITS:0] position, zero padded to whole bytes
   input  logic [((FRAC_BITS + 8) / 8) * 8 - 1:0] req_tdata,
   // item out
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue
   output logic [cmap_li_pkg::RGB_W-1:0]         rsp_tdata,
   // [0] range_error
   output logic                                  rsp_tuser,
   // control point writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cmap_li_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cmap_li_pkg::POS_SHIFT+FRAC_BITS:0] csr_data
);

   localparam int REG_W = cmap_li_pkg::POS_SHIFT + FRAC_BITS + 1;
   localparam int PW    = FRAC_BITS + 1;
   localparam int NW    = cmap_li_pkg::num_w(FRAC_BITS);
   localparam int NC    = cmap_li_pkg::N_CHAN;
   localparam int NSTG  = cmap_li_pkg::N_STAGES;
   localparam logic [REG_W-1:0] POINT_RST =
      (REG_W'(1) << (cmap_li_pkg::POS_SHIFT + FRAC_BITS)) |
      REG_W'(cmap_li_pkg::WHITE_RGB);

   // ---------------------------------------------------------------
   // Control point registers. Writes beyond the stored points drop.
   // ---------------------------------------------------------------
   logic [NUM_POINTS-1:0][REG_W-1:0] point_ff;
   logic [NUM_POINTS-1:0][REG_W-1:0] point_in;

   assign csr_ready = 1'b1;

   always_comb begin
      point_in = point_ff;
      for (int i = 0; i < NUM_POINTS; i++) begin
         if (csr_valid && (csr_index == cmap_li_pkg::CSR_IDX_W'(i))) begin
            point_in[i] = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POINTS; i++) begin
            point_ff[i] <= (i == 0) ? '0 : POINT_RST;
         end
      end else begin
         point_ff <= point_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage valid chain. A stage loads when it is empty or when the
   // stage after it loads, so bubbles close up and a full output
   // register still lets earlier stages fill.
   // ---------------------------------------------------------------
   cmap_li_pkg::stage_en_type en;
   cmap_li_pkg::stage_en_type vld_ff;
   cmap_li_pkg::stage_en_type vld_in;
   cmap_li_pkg::stage_en_type vld_src;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] | rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] | en[k+1];
      end
   end

   assign vld_src = {vld_ff[NSTG-2:0], req_tvalid};
   assign vld_in  = (en & vld_src) | (~en & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[cmap_li_pkg::ST_SEG];
   assign rsp_tvalid = vld_ff[cmap_li_pkg::ST_OUT];

   // ---------------------------------------------------------------
   // Segment search and point selection
   // ---------------------------------------------------------------
   logic [PW-1:0]        x_s, pa_s, pb_s;
   cmap_li_pkg::rgb_type ca_s, cb_s;
   logic                 err_s;

   cmap_li_seg #(
      .NUM_POINTS (NUM_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_seg (
      .clock  (clock),
      .en     (en[cmap_li_pkg::ST_SEG]),
      .x_i    (req_tdata[PW-1:0]),
      .points (point_ff),
      .x_ff   (x_s),
      .pa_ff  (pa_s),
      .pb_ff  (pb_s),
      .ca_ff  (ca_s),
      .cb_ff  (cb_s),
      .err_ff (err_s)
   );

   // ---------------------------------------------------------------
   // Differences, numerators, magnitudes
   // ---------------------------------------------------------------
   logic [NC-1:0][NW-1:0]              mag_n;
   logic [PW-1:0]                      mag_d;
   cmap_li_pkg::chan_tag_type [NC-1:0] tag;

   cmap_li_arith #(
      .FRAC_BITS (FRAC_BITS)
   ) u_arith (
      .clock    (clock),
      .en       (en[cmap_li_pkg::ST_ARITH +: 3]),
      .x_i      (x_s),
      .pa_i     (pa_s),
      .pb_i     (pb_s),
      .ca_i     (ca_s),
      .cb_i     (cb_s),
      .err_i    (err_s),
      .mag_n_ff (mag_n),
      .mag_d_ff (mag_d),
      .tag_ff   (tag)
   );

   // ---------------------------------------------------------------
   // One divider per channel, run in lockstep
   // ---------------------------------------------------------------
   cmap_li_pkg::rgb_type chan_val;
   logic [NC-1:0]        chan_err;

   for (genvar c = 0; c < NC; c++) begin : g_chan
      cmap_li_div #(
         .NW (NW),
         .DW (PW)
      ) u_div (
         .clock (clock),
         .en    (en[cmap_li_pkg::ST_DIV +: cmap_li_pkg::DIV_STAGES]),
         .rem_i (mag_n[c]),
         .d_i   (mag_d),
         .tag_i (tag[c]),
         .val_o (chan_val[c]),
         .err_o (chan_err[c])
      );
   end

   // ---------------------------------------------------------------
   // Output register: hold while the consumer stalls
   // ---------------------------------------------------------------
   cmap_li_pkg::rgb_type rsp_data_ff;
   logic                 rsp_err_ff;

   always_ff @(posedge clock) begin
      if (en[cmap_li_pkg::ST_OUT]) begin
         rsp_data_ff <= chan_val;
         rsp_err_ff  <= chan_err[0];
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_err_ff;

endmodule

// File: rtl/cmap_li_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the colour gradient block, bound to the top level.
// Depends on colormap_linear_interp_top and cmap_li_pkg.
module cmap_li_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [cmap_li_pkg::RGB_W-1:0] rsp_tdata,
   input logic                          rsp_tuser
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // out-of-range positions give black
   a_err_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("range error with non-zero colour");

   // an empty output register lets the whole pipeline advance
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // a taken output frees room for a new item in the same cycle
   a_take_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind colormap_linear_interp_top cmap_li_chk u_cmap_li_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: test/colormap_linear_interp_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for colormap_linear_interp_top: drives positions and control-point
// writes, predicts each colour and range flag, and compares them with the result stream.
// Depends on cmap_li_pkg and the colormap_linear_interp_top RTL.
module colormap_linear_interp_top_tb;

   localparam int CHAN_W     = cmap_li_pkg::CHAN_W;
   localparam int RGB_W      = cmap_li_pkg::RGB_W;
   localparam int POS_SHIFT  = cmap_li_pkg::POS_SHIFT;
   localparam int CSR_IDX_W  = cmap_li_pkg::CSR_IDX_W;
   localparam int NUM_POINTS = 8;
   localparam int FRAC_BITS  = 16;
   localparam int POS_W      = FRAC_BITS + 1;
   localparam int REQ_W      = ((FRAC_BITS + 8) / 8) * 8;
   localparam int PT_W       = POS_SHIFT + FRAC_BITS + 1;
   localparam int N_REGS     = 8;
   // index past the point file; such writes must be dropped
   localparam int IDX_BEYOND = 9;
   localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;
   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam int SETTLE     = 12;
   localparam longint LIMIT  = 400000;

   typedef enum int {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_type;

   typedef struct {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              range_error;
   } colour_type;

   // Holds its own copy of the point file and the colours still owed by the block.
   class colour_scoreboard;
      logic [PT_W-1:0] points[N_REGS];
      colour_type      owed[$];
      int fail_count;
      int matched;
      int range_hits;

      function new();
         points[0] = '0;
         for (int i = 1; i < N_REGS; i++)
            points[i] = (PT_W'(POS_ONE) << POS_SHIFT) | PT_W'(cmap_li_pkg::WHITE_RGB);
         fail_count = 0;
         matched = 0;
         range_hits = 0;
      endfunction

      function void write_point(int idx, logic [PT_W-1:0] value);
         if (idx < N_REGS)
            points[idx] = value;
      endfunction

      function longint point_pos(int idx);
         return longint'(points[idx][PT_W-1:POS_SHIFT]);
      endfunction

      // blend one channel between points ia and ib, truncate towards zero, clamp
      function logic [CHAN_W-1:0] blend_channel(int ia, int ib, longint x, int shift);
         longint pa, pb, ca, cb, den, val;
         pa = point_pos(ia);
         pb = point_pos(ib);
         ca = longint'((points[ia] >> shift) & 'hFF);
         cb = longint'((points[ib] >> shift) & 'hFF);
         den = pb - pa;
         if (den == 0)
            return CHAN_W'(cb);
         val = (cb * (x - pa) + ca * (pb - x)) / den;
         if (val < 0)
            val = 0;
         if (val > 255)
            val = 255;
         return CHAN_W'(val);
      endfunction

      function void note_position(logic [POS_W-1:0] position);
         colour_type c;
         longint x;
         int seg;
         x = longint'(position);
         seg = 0;
         if (position > POS_ONE) begin
            c.red = '0;
            c.green = '0;
            c.blue = '0;
            c.range_error = 1'b1;
         end else begin
            while (seg < NUM_POINTS - 2 && point_pos(seg + 1) < x)
               seg++;
            c.red = blend_channel(seg, seg + 1, x, 16);
            c.green = blend_channel(seg, seg + 1, x, 8);
            c.blue = blend_channel(seg, seg + 1, x, 0);
            c.range_error = 1'b0;
         end
         owed.insert(owed.size(), c);
      endfunction

      function void check_colour(logic [RGB_W-1:0] data, logic err);
         colour_type c;
         if (owed.size() == 0) begin
            $error("result with nothing expected: data %h range_error %b", data, err);
            fail_count++;
            return;
         end
         c = owed.pop_front();
         if (data[7:0] !== c.red) begin
            $error("red: expected %0d, actual %0d", c.red, data[7:0]);
            fail_count++;
         end
         if (data[15:8] !== c.green) begin
            $error("green: expected %0d, actual %0d", c.green, data[15:8]);
            fail_count++;
         end
         if (data[23:16] !== c.blue) begin
            $error("blue: expected %0d, actual %0d", c.blue, data[23:16]);
            fail_count++;
         end
         if (err !== c.range_error) begin
            $error("range_error: expected %0d, actual %0d", c.range_error, err);
            fail_count++;
         end
         matched++;
         if (c.range_error)
            range_hits++;
      endfunction

      function int pending();
         return owed.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RGB_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [PT_W-1:0]       csr_data;

   colour_scoreboard sb;
   longint cycles = 0;
   int     sent_items = 0;
   int     csr_writes = 0;
   int     send_idle_pct = 0;
   int     recv_stall_pct = 0;

   colormap_linear_interp_top #(
      .NUM_POINTS (NUM_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Sample both streams at the rising edge; the input item is noted before the
   // result is checked, which is safe as every item passes the pipeline registers first.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
         $display("colormap_linear_interp_top_tb failed");
         $finish;
      end else if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_position(req_tdata[POS_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            sb.check_colour(rsp_tdata, rsp_tuser);
      end
   end

   // Receiver back-pressure, redrawn on every falling edge; held low in reset
   always @(negedge clock) begin
      if (reset)
         rsp_tready = 1'b0;
      else
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic void set_flow(flow_type f);
      case (f)
         FLOW_FREE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         FLOW_SEND_IDLE: begin
            send_idle_pct = 78;
            recv_stall_pct = 0;
         end
         FLOW_RECV_STALL: begin
            send_idle_pct = 0;
            recv_stall_pct = 78;
         end
         default: begin
            send_idle_pct = 33;
            recv_stall_pct = 33;
         end
      endcase
   endfunction

   // Enter and leave on a falling edge. Valid stays high between back-to-back
   // items so that it is never dropped and raised again in one step.
   task automatic send_position(logic [POS_W-1:0] position);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = REQ_W'(position);
      do
         @(posedge clock);
      while (!req_tready);
      sent_items++;
      @(negedge clock);
   endtask

   // Hold off until every owed colour has arrived, then let the pipe empty.
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_csr(int idx, logic [PT_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = CSR_IDX_W'(idx);
      csr_data = value;
      do
         @(posedge clock);
      while (!csr_ready);
      sb.write_point(idx, value);
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [PT_W-1:0] make_point(logic [POS_W-1:0] pos, logic [RGB_W-1:0] rgb);
      return {pos, rgb};
   endfunction

   // Well-formed map: ascending positions inside [0, 1.0], duplicates now and then.
   task automatic load_sorted_map();
      logic [POS_W-1:0] pos[N_REGS];
      logic [POS_W-1:0] tmp;
      for (int i = 0; i < N_REGS; i++)
         pos[i] = POS_W'($urandom_range(0, POS_ONE));
      if ($urandom_range(1))
         pos[$urandom_range(N_REGS - 1)] = pos[$urandom_range(N_REGS - 1)];
      for (int i = 0; i < N_REGS; i++)
         for (int j = 0; j < N_REGS - 1 - i; j++)
            if (pos[j] > pos[j + 1]) begin
               tmp = pos[j];
               pos[j] = pos[j + 1];
               pos[j + 1] = tmp;
            end
      for (int i = 0; i < N_REGS; i++)
         write_csr(i, make_point(pos[i], RGB_W'($urandom)));
   endtask

   // Noise: any 41-bit value, so positions above one and unsorted points too.
   task automatic load_noise_map();
      for (int i = 0; i < N_REGS; i++)
         write_csr(i, {9'($urandom), 32'($urandom)});
   endtask

   function automatic logic [POS_W-1:0] pick_position();
      int r;
      int k;
      int p;
      r = $urandom_range(99);
      if (r < 65)
         return POS_W'($urandom_range(0, POS_ONE));
      if (r < 80) begin
         // land on or right beside a control point
         k = $urandom_range(N_REGS - 1);
         p = int'(sb.points[k][PT_W-1:POS_SHIFT]) + $urandom_range(0, 4) - 2;
         if (p < 0)
            p = 0;
         if (p > int'(POS_MAX))
            p = int'(POS_MAX);
         return POS_W'(p);
      end
      if (r < 90) begin
         case ($urandom_range(3))
            0: return '0;
            1: return POS_ONE;
            2: return POS_ONE + 1'b1;
            default: return POS_MAX;
         endcase
      end
      return POS_W'($urandom_range(POS_ONE + 1, POS_MAX));
   endfunction

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset map: black at 0.0 rising to white at 1.0, plus the range edges.
      set_flow(FLOW_FREE);
      send_position('0);
      send_position(POS_W'(1));
      send_position(POS_ONE >> 1);
      send_position(POS_ONE - 1'b1);
      send_position(POS_ONE);
      send_position(POS_ONE + 1'b1);
      send_position(POS_MAX);
      drain();

      // Hand-built map: first point above zero so low inputs extrapolate, a
      // zero-width segment in the middle, and the last point short of one.
      write_csr(0, make_point(POS_W'('h1000), 24'h10_80_F0));
      write_csr(1, make_point(POS_W'('h4000), 24'hFF_00_00));
      write_csr(2, make_point(POS_W'('h8000), 24'h00_FF_00));
      write_csr(3, make_point(POS_W'('h8000), 24'h00_00_FF));
      write_csr(4, make_point(POS_W'('hC000), 24'hFF_FF_00));
      write_csr(5, make_point(POS_W'('hC800), 24'h00_FF_FF));
      write_csr(6, make_point(POS_W'('hD000), 24'h40_40_40));
      write_csr(7, make_point(POS_W'('hE000), 24'hC0_20_80));
      send_position('0);
      send_position(POS_W'('h1000));
      send_position(POS_W'('h2345));
      send_position(POS_W'('h8000));
      send_position(POS_W'('hF000));
      send_position(POS_ONE);
      drain();

      // Unsorted map with all-ones and all-zeros registers; a write past the
      // point file must leave point 1 untouched.
      write_csr(0, '1);
      write_csr(1, '0);
      write_csr(2, make_point(POS_ONE, 24'h00_00_00));
      write_csr(3, make_point(POS_W'('h6000), 24'hFF_FF_FF));
      write_csr(IDX_BEYOND, '1);
      send_position('0);
      send_position(POS_W'('h3000));
      send_position(POS_W'('h7000));
      send_position(POS_ONE);
      send_position(POS_W'('h5555));
      drain();

      // Random phases: eight maps, each flow pattern twice.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 3 || phase == 6)
            load_noise_map();
         else
            load_sorted_map();
         if (phase == 5)
            write_csr($urandom_range(N_REGS, (1 << CSR_IDX_W) - 1),
                      {9'($urandom), 32'($urandom)});
         set_flow(flow_type'(phase % 4));
         for (int n = 0; n < 50; n++) begin
            send_position(pick_position());
            // pause mid-stream until every owed colour is back
            if (phase == 1 && n == 25)
               drain();
         end
         drain();
      end

      set_flow(FLOW_FREE);
      drain();
      $display("covered %0d items and %0d point writes over reset, directed,",
               sent_items, csr_writes);
      $display("sorted and noise maps; %0d colours checked, %0d of them out of range",
               sb.matched, sb.range_hits);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("colormap_linear_interp_top_tb passed");
      end else begin
         $display("colormap_linear_interp_top_tb failed");
      end
      $finish;
   end

endmodule
